>>> design/iopc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 option padding checker - shared package
// Types, parse phases and queue item layout used by front, queue and back.
// ----------------------------------------------------------------------------
package iopc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam logic [9:0] COUNT_MAX = 10'd1023;

  localparam logic [7:0] OPT_PAD1 = 8'd0;
  localparam logic [7:0] OPT_PADN = 8'd1;

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_OPT   = 1'b1
  } kind_t;

  // one queued item from the front part to the back part
  typedef struct packed {
    kind_t       kind;
    logic        last;
    logic [7:0]  data;
    logic [11:0] hlen;
  } iopc_item_t;

endpackage : iopc_pkg
`default_nettype wire

>>> design/iopc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 option padding checker - front part
// Tracks byte position and header length, drops bytes outside a header and
// tags option bytes (with last-byte flag) for the back part.
// ----------------------------------------------------------------------------
module iopc_front
  import iopc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] hdr_byte,
  input  wire logic       first_byte,
  output logic            push,
  output iopc_item_t      push_item
);

  logic [10:0] pos;
  logic [10:0] pos_next;
  logic [11:0] hlen;
  logic [11:0] hlen_next;
  logic        is_last;

  assign is_last = ({1'b0, pos} + 12'd1) >= hlen;

  always_comb begin
    pos_next       = pos;
    hlen_next      = hlen;
    push           = 1'b0;
    push_item.kind = KIND_OPT;
    push_item.last = 1'b0;
    push_item.data = hdr_byte;
    push_item.hlen = hlen;
    if (accept) begin
      if (first_byte) begin
        push           = 1'b1;
        push_item.kind = KIND_START;
        pos_next       = 11'd1;
      end else if (pos == 11'd0) begin
        // idle: byte ignored
      end else if (pos == 11'd1) begin
        hlen_next = {({1'b0, hdr_byte} + 9'd1), 3'b000};
        pos_next  = 11'd2;
      end else begin
        push           = 1'b1;
        push_item.last = is_last;
        pos_next       = is_last ? 11'd0 : pos + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      hlen <= '0;
    end else begin
      pos  <= pos_next;
      hlen <= hlen_next;
    end
  end

endmodule : iopc_front
`default_nettype wire

>>> design/iopc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 option padding checker - item queue
// Small FIFO between front and back parts.
// ----------------------------------------------------------------------------
module iopc_queue
  import iopc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire iopc_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output iopc_item_t      pop_item,
  output logic            empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  iopc_item_t      mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue push while full");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not advance on push");

endmodule : iopc_queue
`default_nettype wire

>>> design/iopc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// IPv6 option padding checker - back part
// Walks option TLVs one byte per item and registers the header result.
// ----------------------------------------------------------------------------
module iopc_back
  import iopc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire iopc_item_t  item,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             length_error,
  output logic             consecutive_padding,
  output logic [9:0]       nonzero_padn_count,
  output logic             pad_only,
  output logic [11:0]      header_bytes
);

  phase_t      phase, phase_next;
  logic [7:0]  left, left_next;
  logic        in_padn, in_padn_next;
  logic        prev_pad, prev_pad_next;
  logic        consec, consec_next;
  logic        allpad, allpad_next;
  logic        seen, seen_next;
  logic [9:0]  count, count_next;
  logic        finish;
  logic [7:0]  b;

  assign b      = item.data;
  assign finish = !empty && (item.kind == KIND_OPT) && item.last;
  // a result item may only be produced once the output register frees up
  assign pop    = !empty && (!finish || !out_valid || out_ready);

  always_comb begin
    phase_next    = phase;
    left_next     = left;
    in_padn_next  = in_padn;
    prev_pad_next = prev_pad;
    consec_next   = consec;
    allpad_next   = allpad;
    seen_next     = seen;
    count_next    = count;
    unique case (phase)
      PH_TYPE: begin
        if (b == OPT_PAD1 || b == OPT_PADN) begin
          if (prev_pad) begin
            consec_next = 1'b1;
          end
          prev_pad_next = 1'b1;
          if (b == OPT_PADN) begin
            in_padn_next = 1'b1;
            seen_next    = 1'b0;
            phase_next   = PH_LEN;
          end
        end else begin
          allpad_next   = 1'b0;
          prev_pad_next = 1'b0;
          in_padn_next  = 1'b0;
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        left_next  = b;
        phase_next = (b == 8'd0) ? PH_TYPE : PH_DATA;
      end
      default: begin
        if (in_padn && b != 8'd0 && !seen) begin
          seen_next = 1'b1;
          if (count != COUNT_MAX) begin
            count_next = count + 10'd1;
          end
        end
        if (left != 8'd0) begin
          left_next = left - 8'd1;
        end
        if (left_next == 8'd0) begin
          phase_next = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_TYPE;
      left     <= '0;
      in_padn  <= 1'b0;
      prev_pad <= 1'b0;
      consec   <= 1'b0;
      allpad   <= 1'b1;
      seen     <= 1'b0;
      count    <= '0;
    end else if (pop) begin
      if (item.kind == KIND_START || item.last) begin
        phase    <= PH_TYPE;
        left     <= '0;
        in_padn  <= 1'b0;
        prev_pad <= 1'b0;
        consec   <= 1'b0;
        allpad   <= 1'b1;
        seen     <= 1'b0;
        count    <= '0;
      end else begin
        phase    <= phase_next;
        left     <= left_next;
        in_padn  <= in_padn_next;
        prev_pad <= prev_pad_next;
        consec   <= consec_next;
        allpad   <= allpad_next;
        seen     <= seen_next;
        count    <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && finish) begin
      length_error        <= (phase_next != PH_TYPE);
      consecutive_padding <= consec_next;
      nonzero_padn_count  <= count_next;
      pad_only            <= allpad_next;
      header_bytes        <= item.hlen;
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (pop && finish) |=> out_valid)
    else $error("finished header produced no result");

  a_hlen_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (header_bytes[2:0] == 3'd0 && header_bytes != 12'd0))
    else $error("header length not a nonzero multiple of 8");

endmodule : iopc_back
`default_nettype wire

>>> design/ipv6_option_padding_checker.sv
`default_nettype none
// Throughput: one byte item per cycle while in_ready is high; the back part walks one
// option byte per cycle and stalls only while a result waits in its output register.
// Result path: the last header byte is written into the queue; out_valid is set
// as that item leaves the queue and loads the result register.
// Reset: synchronous active-high rst empties the queue, closes any open header
// and drops a pending result.
// ----------------------------------------------------------------------------
// IPv6 option padding checker - top level
// Front part classifies header bytes, queue decouples, back part parses TLVs.
// ----------------------------------------------------------------------------
module ipv6_option_padding_checker
  import iopc_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  hdr_byte,
  input  wire logic        first_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             length_error,
  output logic             consecutive_padding,
  output logic [9:0]       nonzero_padn_count,
  output logic             pad_only,
  output logic [11:0]      header_bytes
);

  logic       accept;
  logic       push;
  iopc_item_t push_item;
  logic       full;
  logic       pop;
  iopc_item_t pop_item;
  logic       empty;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  iopc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .hdr_byte   (hdr_byte),
    .first_byte (first_byte),
    .push       (push),
    .push_item  (push_item)
  );

  iopc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  iopc_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .item                (pop_item),
    .empty               (empty),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .length_error        (length_error),
    .consecutive_padding (consecutive_padding),
    .nonzero_padn_count  (nonzero_padn_count),
    .pad_only            (pad_only),
    .header_bytes        (header_bytes)
  );

endmodule : ipv6_option_padding_checker
`default_nettype wire
